// ----- rtl/vpa_pkg.sv -----
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared constants, command and status codes, and the request structs that
// travel between the voice pool allocator and its storage blocks.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int VOICES_PER_TYPE_DEF = 32;
    localparam int VOICE_TYPES_DEF     = 2;

    localparam int CMD_W  = 2;
    localparam int TYPE_W = 1;
    localparam int IDX_W  = 5;
    localparam int TICK_W = 32;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 2'd2;

    // free fifo request: pop at head or push at tail of one type
    typedef struct packed {
        logic              pop;
        logic              push;
        logic [TYPE_W-1:0] vtype;
        logic [IDX_W-1:0]  voice;
    } fifo_cmd_t;

    // release tick store request: write, clear, and the shared address
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic [TYPE_W-1:0] vtype;
        logic [IDX_W-1:0]  voice;
        logic [TICK_W-1:0] tick;
    } tick_cmd_t;

endpackage

// ----- rtl/vpa_free_fifo.sv -----
// ----------------------------------------------------------------------------
// vpa_free_fifo
// Per-type ring of free voices in one memory. Entries never written read as
// their slot number, which gives the ascending fill after reset.
// ----------------------------------------------------------------------------
module vpa_free_fifo #(
    parameter int VOICES_PER_TYPE = vpa_pkg::VOICES_PER_TYPE_DEF,
    parameter int VOICE_TYPES     = vpa_pkg::VOICE_TYPES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vpa_pkg::fifo_cmd_t         cmd,
    output logic [vpa_pkg::IDX_W-1:0]  rd_data
);
    import vpa_pkg::*;

    localparam int SLOT_W = (VOICES_PER_TYPE > 1) ? $clog2(VOICES_PER_TYPE) : 1;
    localparam int CNT_W  = $clog2(VOICES_PER_TYPE + 1);

    logic [IDX_W-1:0]  free_mem [VOICE_TYPES][VOICES_PER_TYPE];
    logic [VOICE_TYPES-1:0][VOICES_PER_TYPE-1:0] vld_reg;
    logic [VOICE_TYPES-1:0][SLOT_W-1:0] head_reg;
    logic [VOICE_TYPES-1:0][CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  rd_data_reg;

    logic [SLOT_W-1:0] head;
    logic [CNT_W:0]    tail_sum;
    logic [SLOT_W-1:0] tail;
    logic [SLOT_W-1:0] head_inc;

    assign head     = head_reg[cmd.vtype];
    assign tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(cnt_reg[cmd.vtype]);
    assign tail     = (tail_sum >= (CNT_W+1)'(VOICES_PER_TYPE))
                    ? SLOT_W'(tail_sum - (CNT_W+1)'(VOICES_PER_TYPE))
                    : SLOT_W'(tail_sum);
    assign head_inc = (head == SLOT_W'(VOICES_PER_TYPE - 1)) ? '0 : SLOT_W'(head + 1'b1);
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            head_reg <= '0;
            for (int t = 0; t < VOICE_TYPES; t++)
            begin
                cnt_reg[t] <= CNT_W'(VOICES_PER_TYPE);
            end
        end
        else if (cmd.pop)
        begin
            head_reg[cmd.vtype] <= head_inc;
            cnt_reg[cmd.vtype]  <= cnt_reg[cmd.vtype] - 1'b1;
        end
        else if (cmd.push)
        begin
            vld_reg[cmd.vtype][tail] <= 1'b1;
            cnt_reg[cmd.vtype]       <= cnt_reg[cmd.vtype] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            free_mem[cmd.vtype][tail] <= cmd.voice;
        end
        rd_data_reg <= vld_reg[cmd.vtype][head] ? free_mem[cmd.vtype][head]
                                                : IDX_W'(head);
    end

endmodule

// ----- rtl/vpa_tick_ram.sv -----
// ----------------------------------------------------------------------------
// vpa_tick_ram
// Release tick memory, one word per voice. A cleared valid bit reads as zero.
// ----------------------------------------------------------------------------
module vpa_tick_ram #(
    parameter int VOICES_PER_TYPE = vpa_pkg::VOICES_PER_TYPE_DEF,
    parameter int VOICE_TYPES     = vpa_pkg::VOICE_TYPES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vpa_pkg::tick_cmd_t          cmd,
    output logic [vpa_pkg::TICK_W-1:0]  rd_data
);
    import vpa_pkg::*;

    localparam int SLOT_W = (VOICES_PER_TYPE > 1) ? $clog2(VOICES_PER_TYPE) : 1;

    logic [TICK_W-1:0] tick_mem [VOICE_TYPES][VOICES_PER_TYPE];
    logic [VOICE_TYPES-1:0][VOICES_PER_TYPE-1:0] vld_reg;
    logic [TICK_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] slot;

    assign slot    = cmd.voice[SLOT_W-1:0];
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.wr)
        begin
            vld_reg[cmd.vtype][slot] <= 1'b1;
        end
        else if (cmd.clr)
        begin
            vld_reg[cmd.vtype][slot] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            tick_mem[cmd.vtype][slot] <= cmd.tick;
        end
        rd_data_reg <= vld_reg[cmd.vtype][slot] ? tick_mem[cmd.vtype][slot] : '0;
    end

endmodule

// ----- rtl/voice_pool_allocator.sv -----
// steps: allocate pops the free fifo and emits from S_ALLOC, an empty pool emits
// straight away; free and sweep walk the active list memory one entry at a time
// through S_WRD, S_WVOICE and S_WDEC; set release finishes in S_IDLE.
// throughput: one item at a time; a new command is taken only in S_IDLE.
// reset: asynchronous, all pools ready at once, no clearing pass.
// ----------------------------------------------------------------------------
// voice_pool_allocator
// Free fifo and ordered active list per voice type, with allocate, set
// release, free and sweep commands driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
module voice_pool_allocator #(
    parameter int VOICES_PER_TYPE = vpa_pkg::VOICES_PER_TYPE_DEF,
    parameter int VOICE_TYPES     = vpa_pkg::VOICE_TYPES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [vpa_pkg::CMD_W-1:0]   cmd,
    input  logic [vpa_pkg::TYPE_W-1:0]  voice_type,
    input  logic [vpa_pkg::IDX_W-1:0]   voice_index,
    input  logic [vpa_pkg::TICK_W-1:0]  release_tick,
    input  logic [vpa_pkg::TICK_W-1:0]  work_tick,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [vpa_pkg::TYPE_W-1:0]  out_type,
    output logic [vpa_pkg::IDX_W-1:0]   out_index,
    output logic [vpa_pkg::STAT_W-1:0]  status,
    output logic                        reclaimed,
    output logic                        last
);
    import vpa_pkg::*;

    localparam int SLOT_W = (VOICES_PER_TYPE > 1) ? $clog2(VOICES_PER_TYPE) : 1;
    localparam int CNT_W  = $clog2(VOICES_PER_TYPE + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ALLOC, S_WRD, S_WVOICE, S_WDEC, S_EMIT
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [TYPE_W-1:0] typ_reg, typ_next;
    logic [IDX_W-1:0]  vin_reg, vin_next;
    logic [TICK_W-1:0] wtick_reg, wtick_next;
    logic [CNT_W-1:0]  r_reg, r_next, w_reg, w_next, len_reg, len_next;
    logic [IDX_W-1:0]  voice_reg, voice_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [TYPE_W-1:0] pend_typ_reg, pend_typ_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [TYPE_W-1:0] res_typ_reg, res_typ_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [STAT_W-1:0] res_st_reg, res_st_next;
    logic              res_rec_reg, res_rec_next;
    logic              res_last_reg, res_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0] out_type_reg, out_type_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              reclaimed_reg, reclaimed_next;
    logic              last_reg, last_next;
    logic [VOICE_TYPES-1:0][CNT_W-1:0] act_cnt_reg, act_cnt_next;
    logic [VOICE_TYPES-1:0][VOICES_PER_TYPE-1:0] flag_reg, flag_next;

    // active list memory
    logic [IDX_W-1:0]  act_mem [VOICE_TYPES][VOICES_PER_TYPE];
    logic [IDX_W-1:0]  act_rd_reg;
    logic              act_we;
    logic [SLOT_W-1:0] act_wslot;
    logic [IDX_W-1:0]  act_wdata;

    fifo_cmd_t         fifo_cmd;
    tick_cmd_t         tick_cmd;
    logic [IDX_W-1:0]  fifo_rd;
    logic [TICK_W-1:0] tick_rd;

    logic accept, out_free, type_ok, idx_ok, drop;

    vpa_free_fifo #(
        .VOICES_PER_TYPE (VOICES_PER_TYPE),
        .VOICE_TYPES     (VOICE_TYPES)
    ) u_free_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (fifo_cmd),
        .rd_data (fifo_rd)
    );

    vpa_tick_ram #(
        .VOICES_PER_TYPE (VOICES_PER_TYPE),
        .VOICE_TYPES     (VOICE_TYPES)
    ) u_tick_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tick_cmd),
        .rd_data (tick_rd)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign type_ok   = (32'(voice_type) < VOICE_TYPES);
    assign idx_ok    = (32'(voice_index) < VOICES_PER_TYPE);
    assign drop      = (cmd_reg == CMD_FREE) ? (voice_reg == vin_reg)
                     : ((tick_rd != '0) && (tick_rd < wtick_reg));

    assign out_valid = out_valid_reg;
    assign out_type  = out_type_reg;
    assign out_index = out_index_reg;
    assign status    = status_reg;
    assign reclaimed = reclaimed_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cmd_next       = cmd_reg;
        typ_next       = typ_reg;
        vin_next       = vin_reg;
        wtick_next     = wtick_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        len_next       = len_reg;
        voice_next     = voice_reg;
        pend_vld_next  = pend_vld_reg;
        pend_typ_next  = pend_typ_reg;
        pend_idx_next  = pend_idx_reg;
        res_typ_next   = res_typ_reg;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        res_rec_next   = res_rec_reg;
        res_last_next  = res_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_type_next  = out_type_reg;
        out_index_next = out_index_reg;
        status_next    = status_reg;
        reclaimed_next = reclaimed_reg;
        last_next      = last_reg;
        act_cnt_next   = act_cnt_reg;
        flag_next      = flag_reg;
        act_we         = 1'b0;
        act_wslot      = w_reg[SLOT_W-1:0];
        act_wdata      = voice_reg;
        fifo_cmd       = '0;
        fifo_cmd.vtype = typ_reg;
        fifo_cmd.voice = voice_reg;
        tick_cmd       = '0;
        tick_cmd.vtype = typ_reg;
        tick_cmd.voice = act_rd_reg;
        tick_cmd.tick  = release_tick;

        case (state_reg)
            S_IDLE:
            begin
                tick_cmd.vtype = voice_type;
                tick_cmd.voice = voice_index;
                if (accept)
                begin
                    cmd_next   = cmd;
                    typ_next   = voice_type;
                    vin_next   = voice_index;
                    wtick_next = work_tick;
                    r_next     = '0;
                    w_next     = '0;
                    ret_next   = S_IDLE;
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            if (type_ok
                                && act_cnt_reg[voice_type] != CNT_W'(VOICES_PER_TYPE))
                            begin
                                fifo_cmd.pop   = 1'b1;
                                fifo_cmd.vtype = voice_type;
                                state_next     = S_ALLOC;
                            end
                            else
                            begin
                                res_typ_next  = voice_type;
                                res_idx_next  = '0;
                                res_st_next   = ST_EMPTY;
                                res_rec_next  = 1'b0;
                                res_last_next = 1'b1;
                                state_next    = S_EMIT;
                            end
                        end
                        CMD_SET:
                        begin
                            tick_cmd.wr = type_ok && idx_ok;
                        end
                        CMD_FREE:
                        begin
                            if (type_ok && idx_ok
                                && flag_reg[voice_type][voice_index[SLOT_W-1:0]])
                            begin
                                len_next   = act_cnt_reg[voice_type];
                                state_next = S_WRD;
                            end
                            else
                            begin
                                res_typ_next  = voice_type;
                                res_idx_next  = voice_index;
                                res_st_next   = ST_NOT_ACTIVE;
                                res_rec_next  = 1'b0;
                                res_last_next = 1'b1;
                                state_next    = S_EMIT;
                            end
                        end
                        default:
                        begin
                            typ_next      = '0;
                            len_next      = act_cnt_reg[0];
                            pend_vld_next = 1'b0;
                            state_next    = S_WRD;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                // head voice arrives from the free fifo
                flag_next[typ_reg][fifo_rd[SLOT_W-1:0]] = 1'b1;
                tick_cmd.clr   = 1'b1;
                tick_cmd.voice = fifo_rd;
                act_we         = 1'b1;
                act_wslot      = act_cnt_reg[typ_reg][SLOT_W-1:0];
                act_wdata      = fifo_rd;
                act_cnt_next[typ_reg] = act_cnt_reg[typ_reg] + 1'b1;
                res_typ_next   = typ_reg;
                res_idx_next   = fifo_rd;
                res_st_next    = ST_OK;
                res_rec_next   = 1'b0;
                res_last_next  = 1'b1;
                ret_next       = S_IDLE;
                state_next     = S_EMIT;
            end
            S_WRD:
            begin
                if (r_reg == len_reg)
                begin
                    if (cmd_reg == CMD_SWEEP && typ_reg == '0 && VOICE_TYPES > 1)
                    begin
                        typ_next = TYPE_W'(1);
                        r_next   = '0;
                        w_next   = '0;
                        len_next = act_cnt_reg[TYPE_W'(VOICE_TYPES - 1)];
                    end
                    else
                    begin
                        res_st_next   = ST_OK;
                        res_last_next = 1'b1;
                        if (cmd_reg == CMD_FREE)
                        begin
                            res_typ_next = typ_reg;
                            res_idx_next = vin_reg;
                            res_rec_next = 1'b0;
                        end
                        else if (pend_vld_reg)
                        begin
                            res_typ_next = pend_typ_reg;
                            res_idx_next = pend_idx_reg;
                            res_rec_next = 1'b1;
                        end
                        else
                        begin
                            res_typ_next = '0;
                            res_idx_next = '0;
                            res_rec_next = 1'b0;
                        end
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    state_next = S_WVOICE;
                end
            end
            S_WVOICE:
            begin
                voice_next = act_rd_reg;
                state_next = S_WDEC;
            end
            S_WDEC:
            begin
                r_next     = r_reg + 1'b1;
                state_next = S_WRD;
                if (drop)
                begin
                    flag_next[typ_reg][voice_reg[SLOT_W-1:0]] = 1'b0;
                    fifo_cmd.push = 1'b1;
                    act_cnt_next[typ_reg] = act_cnt_reg[typ_reg] - 1'b1;
                    if (cmd_reg == CMD_SWEEP)
                    begin
                        pend_vld_next = 1'b1;
                        pend_typ_next = typ_reg;
                        pend_idx_next = voice_reg;
                        // the previous reclaim is known not to be the final one
                        if (pend_vld_reg)
                        begin
                            res_typ_next  = pend_typ_reg;
                            res_idx_next  = pend_idx_reg;
                            res_st_next   = ST_OK;
                            res_rec_next  = 1'b1;
                            res_last_next = 1'b0;
                            ret_next      = S_WRD;
                            state_next    = S_EMIT;
                        end
                    end
                end
                else
                begin
                    // compact kept entries toward the front
                    act_we = 1'b1;
                    w_next = w_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_type_next  = res_typ_reg;
                    out_index_next = res_idx_reg;
                    status_next    = res_st_reg;
                    reclaimed_next = res_rec_reg;
                    last_next      = res_last_reg;
                    state_next     = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            act_cnt_reg   <= '0;
            flag_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
            act_cnt_reg   <= act_cnt_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        typ_reg       <= typ_next;
        vin_reg       <= vin_next;
        wtick_reg     <= wtick_next;
        r_reg         <= r_next;
        w_reg         <= w_next;
        len_reg       <= len_next;
        voice_reg     <= voice_next;
        pend_typ_reg  <= pend_typ_next;
        pend_idx_reg  <= pend_idx_next;
        res_typ_reg   <= res_typ_next;
        res_idx_reg   <= res_idx_next;
        res_st_reg    <= res_st_next;
        res_rec_reg   <= res_rec_next;
        res_last_reg  <= res_last_next;
        out_type_reg  <= out_type_next;
        out_index_reg <= out_index_next;
        status_reg    <= status_next;
        reclaimed_reg <= reclaimed_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[typ_reg][act_wslot] <= act_wdata;
        end
        act_rd_reg <= act_mem[typ_reg][r_reg[SLOT_W-1:0]];
    end

endmodule

// ----- rtl/vpa_chk.sv -----
// ----------------------------------------------------------------------------
// vpa_chk
// Port level checks on the voice pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vpa_chk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [vpa_pkg::CMD_W-1:0]   cmd,
    input  logic [vpa_pkg::TYPE_W-1:0]  voice_type,
    input  logic [vpa_pkg::IDX_W-1:0]   voice_index,
    input  logic [vpa_pkg::TICK_W-1:0]  release_tick,
    input  logic [vpa_pkg::TICK_W-1:0]  work_tick,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [vpa_pkg::TYPE_W-1:0]  out_type,
    input  logic [vpa_pkg::IDX_W-1:0]   out_index,
    input  logic [vpa_pkg::STAT_W-1:0]  status,
    input  logic                        reclaimed,
    input  logic                        last
);
    import vpa_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_type)
        && $stable(out_index) && $stable(status) && $stable(reclaimed) && $stable(last))
        else $error("result beat changed while stalled");

    // error results and failed commands end their item and never report a reclaim
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !reclaimed)
        else $error("error result not final or marked reclaimed");

    // a command that produces results blocks the next beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd != CMD_SET |=> !in_ready)
        else $error("input taken while a command is in progress");

    // set release finishes in S_IDLE and leaves the input ready
    a_set_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == CMD_SET |=> in_ready)
        else $error("set release stalled the input");

endmodule

bind voice_pool_allocator vpa_chk u_vpa_chk (.*);

// ----- sim/voice_pool_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_pool_allocator_tb
// Self-checking bench for the voice pool allocator. Commands are driven over
// the valid/ready input channel. A behavioral model of the free fifos and
// active lists predicts every result beat, and each accepted output beat is
// compared with the oldest prediction. Random idling on both sides, a long
// output hold-off and a full drain pause are included.
// ----------------------------------------------------------------------------
module voice_pool_allocator_tb;
    import vpa_pkg::*;

    localparam int NV         = VOICES_PER_TYPE_DEF;
    localparam int NT         = VOICE_TYPES_DEF;
    localparam int HOLD_CYC   = 400;
    localparam int STALL_LIMIT = 8000;

    typedef struct packed {
        logic [TYPE_W-1:0] vtype;
        logic [IDX_W-1:0]  index;
        logic [STAT_W-1:0] stat;
        logic              recl;
        logic              lst;
    } voice_res_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [CMD_W-1:0]  cmd;
    logic [TYPE_W-1:0] voice_type;
    logic [IDX_W-1:0]  voice_index;
    logic [TICK_W-1:0] release_tick;
    logic [TICK_W-1:0] work_tick;
    logic out_valid;
    logic out_ready;
    logic [TYPE_W-1:0] out_type;
    logic [IDX_W-1:0]  out_index;
    logic [STAT_W-1:0] status;
    logic reclaimed;
    logic last;

    // pool model
    logic [IDX_W-1:0]  free_q [NT][$];
    logic [IDX_W-1:0]  active_q [NT][$];
    bit                is_active [NT][NV];
    logic [TICK_W-1:0] rel_tick [NT][NV];

    voice_res_t pending_q [$];
    int  errors;
    bit  idle_en;
    bit  hold_req;
    int  stall_cnt;

    voice_pool_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .voice_type   (voice_type),
        .voice_index  (voice_index),
        .release_tick (release_tick),
        .work_tick    (work_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_type     (out_type),
        .out_index    (out_index),
        .status       (status),
        .reclaimed    (reclaimed),
        .last         (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic voice_res_t mk_res(logic [TYPE_W-1:0] t, logic [IDX_W-1:0] v,
                                          logic [STAT_W-1:0] s, logic r, logic l);
        voice_res_t res;
        res.vtype = t;
        res.index = v;
        res.stat  = s;
        res.recl  = r;
        res.lst   = l;
        return res;
    endfunction

    task automatic queue_exp(voice_res_t r);
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic pool_reset();
        for (int t = 0; t < NT; t++)
        begin
            free_q[t].delete();
            active_q[t].delete();
            for (int v = 0; v < NV; v++)
            begin
                free_q[t].insert(free_q[t].size(), v[IDX_W-1:0]);
                is_active[t][v] = 1'b0;
                rel_tick[t][v]  = '0;
            end
        end
    endtask

    task automatic retire_voice(int t, int pos);
        logic [IDX_W-1:0] v;
        v = active_q[t][pos];
        active_q[t].delete(pos);
        is_active[t][v] = 1'b0;
        free_q[t].insert(free_q[t].size(), v);
    endtask

    task automatic predict_pool(logic [CMD_W-1:0] c, logic [TYPE_W-1:0] t,
                                logic [IDX_W-1:0] v, logic [TICK_W-1:0] rt,
                                logic [TICK_W-1:0] wt);
        logic [IDX_W-1:0] got;
        int n;
        int i;
        bit found;
        case (c)
            CMD_ALLOC:
            begin
                if (free_q[t].size() == 0)
                    queue_exp(mk_res(t, '0, ST_EMPTY, 1'b0, 1'b1));
                else
                begin
                    got = free_q[t][0];
                    free_q[t].delete(0);
                    is_active[t][got] = 1'b1;
                    rel_tick[t][got]  = '0;
                    active_q[t].insert(active_q[t].size(), got);
                    queue_exp(mk_res(t, got, ST_OK, 1'b0, 1'b1));
                end
            end
            CMD_SET:
                rel_tick[t][v] = rt;
            CMD_FREE:
            begin
                found = 1'b0;
                if (is_active[t][v])
                    for (i = 0; i < active_q[t].size(); i++)
                        if (!found && active_q[t][i] == v)
                        begin
                            retire_voice(int'(t), i);
                            found = 1'b1;
                        end
                queue_exp(mk_res(t, v, found ? ST_OK : ST_NOT_ACTIVE, 1'b0, 1'b1));
            end
            default:
            begin
                n = 0;
                for (int ty = 0; ty < NT; ty++)
                begin
                    i = 0;
                    while (i < active_q[ty].size())
                    begin
                        got = active_q[ty][i];
                        if (rel_tick[ty][got] != 0 && rel_tick[ty][got] < wt)
                        begin
                            retire_voice(ty, i);
                            queue_exp(mk_res(TYPE_W'(ty), got, ST_OK, 1'b1, 1'b0));
                            n++;
                        end
                        else
                            i++;
                    end
                end
                if (n == 0)
                    queue_exp(mk_res('0, '0, ST_OK, 1'b0, 1'b1));
                else
                    pending_q[$].lst = 1'b1;
            end
        endcase
    endtask

    // one input beat, called at a rising edge
    task automatic send_cmd(logic [CMD_W-1:0] c, logic [TYPE_W-1:0] t,
                            logic [IDX_W-1:0] v, logic [TICK_W-1:0] rt,
                            logic [TICK_W-1:0] wt);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        voice_type   <= t;
        voice_index  <= v;
        release_tick <= rt;
        work_tick    <= wt;
        do
            @(posedge clk);
        while (!in_ready);
        predict_pool(c, t, v, rt, wt);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [TICK_W-1:0] rand_tick();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return '0;
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    task automatic send_random();
        logic [TYPE_W-1:0] t;
        logic [IDX_W-1:0]  v;
        int r;
        t = TYPE_W'($urandom_range(0, NT - 1));
        v = IDX_W'($urandom_range(0, NV - 1));
        // mostly target voices that are live so frees and releases do something
        if (active_q[t].size() > 0 && $urandom_range(0, 4) != 0)
            v = active_q[t][$urandom_range(0, active_q[t].size() - 1)];
        r = $urandom_range(0, 99);
        if (r < 32)
            send_cmd(CMD_ALLOC, t, IDX_W'($urandom()), $urandom(), $urandom());
        else if (r < 62)
            send_cmd(CMD_SET, t, v, rand_tick(), $urandom());
        else if (r < 82)
            send_cmd(CMD_FREE, t, v, $urandom(), $urandom());
        else
            send_cmd(CMD_SWEEP, t, v, $urandom(), rand_tick());
    endtask

    task automatic test_directed();
        send_cmd(CMD_ALLOC, 1'b0, '0, '0, '0);
        send_cmd(CMD_ALLOC, 1'b1, 5'd31, '1, '1);
        send_cmd(CMD_ALLOC, 1'b0, '0, '0, '0);
        send_cmd(CMD_SET, 1'b0, 5'd0, '1, '0);
        send_cmd(CMD_SET, 1'b1, 5'd0, 32'd1, '0);
        send_cmd(CMD_SET, 1'b1, 5'd31, 32'd7, '0);      // tick on an idle voice
        send_cmd(CMD_SWEEP, 1'b0, '0, '0, 32'd0);      // nothing reclaimed
        send_cmd(CMD_SWEEP, 1'b0, '0, '0, 32'd1);      // equal tick is not below
        send_cmd(CMD_SWEEP, 1'b1, '1, '1, 32'd2);
        send_cmd(CMD_FREE, 1'b1, 5'd0, '0, '0);        // already reclaimed
        send_cmd(CMD_FREE, 1'b0, 5'd1, '0, '0);
        send_cmd(CMD_FREE, 1'b0, 5'd31, '0, '0);       // never allocated
        send_cmd(CMD_SWEEP, 1'b0, '0, '0, '1);         // max tick does not catch the max release
        send_cmd(CMD_ALLOC, 1'b1, '0, '0, '0);
        send_cmd(CMD_SET, 1'b1, 5'd1, 32'hFFFF_FFFE, '0);
        send_cmd(CMD_ALLOC, 1'b0, '0, '0, '0);
        send_cmd(CMD_SET, 1'b0, 5'd2, 32'd0, '0);      // zero tick never expires
        send_cmd(CMD_SWEEP, 1'b0, '0, '0, '1);
        send_cmd(CMD_FREE, 1'b1, 5'd1, '0, '0);
    endtask

    task automatic test_pool_exhaust();
        // drain and overflow type 1, then type 0, then set ticks everywhere and sweep all
        for (int k = 0; k < NV + 2; k++)
            send_cmd(CMD_ALLOC, 1'b1, '0, '0, '0);
        for (int k = 0; k < NV + 1; k++)
            send_cmd(CMD_ALLOC, 1'b0, '0, '0, '0);
        for (int k = 0; k < NV; k++)
        begin
            send_cmd(CMD_SET, 1'b0, k[IDX_W-1:0], 32'd10 + k, '0);
            send_cmd(CMD_SET, 1'b1, k[IDX_W-1:0], 32'd50 - k, '0);
        end
        send_cmd(CMD_SWEEP, 1'b0, '0, '0, 32'd30);
        send_cmd(CMD_SWEEP, 1'b0, '0, '0, '1);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++)
            send_random();
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++)
            send_random();
    endtask

    task automatic test_drain_pause();
        wait_drained();
        test_random(30);
    endtask

    // result checker
    always @(posedge clk)
    begin
        voice_res_t exp_r;
        voice_res_t got_r;
        if (rst_n && out_valid && out_ready)
        begin
            got_r = mk_res(out_type, out_index, status, reclaimed, last);
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, got_r);
                errors++;
            end
            else
            begin
                exp_r = pending_q[0];
                pending_q.delete(0);
                if (got_r.vtype !== exp_r.vtype)
                    $display("%0t: out_type exp %0d got %0d", $time, exp_r.vtype, got_r.vtype);
                if (got_r.index !== exp_r.index)
                    $display("%0t: out_index exp %0d got %0d", $time, exp_r.index, got_r.index);
                if (got_r.stat !== exp_r.stat)
                    $display("%0t: status exp %0d got %0d", $time, exp_r.stat, got_r.stat);
                if (got_r.recl !== exp_r.recl)
                    $display("%0t: reclaimed exp %0d got %0d", $time, exp_r.recl, got_r.recl);
                if (got_r.lst !== exp_r.lst)
                    $display("%0t: last exp %0d got %0d", $time, exp_r.lst, got_r.lst);
                if (got_r !== exp_r)
                    errors++;
            end
        end
    end

    // output side: random stalls plus the long hold-off
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT + HOLD_CYC)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        errors    = 0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        cmd          <= CMD_ALLOC;
        voice_type   <= '0;
        voice_index  <= '0;
        release_tick <= '0;
        work_tick    <= '0;
        pool_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pool_exhaust();
        test_random(100);
        test_output_hold();
        test_drain_pause();
        test_random(90);
        idle_en = 1'b0;
        test_random(60);

        wait_drained();
        repeat (300) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
